/* sv/pfs_pkg.sv */
// Package for the phase-field stencil step: word formats, queue command,
// config register set and saturating fixed-point helpers.
// No dependencies.
`default_nettype none
package pfs_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int FRAC_BITS       = 24;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [VALUE_WIDTH-1:0]        mag_type;
   typedef logic [VALUE_WIDTH-2:0]        coef_type;
   typedef logic [2*VALUE_WIDTH-1:0]      prod_type;
   typedef logic [2*VALUE_WIDTH:0]        wide_type;

   localparam value_type MAX_VALUE = value_type'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
   localparam value_type MIN_VALUE = value_type'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
   localparam mag_type   NEG_MAG   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam value_type ONE_VALUE = (FRAC_BITS >= VALUE_WIDTH - 1) ? MAX_VALUE :
                                     value_type'(mag_type'(1) << FRAC_BITS);
   localparam wide_type  HALF_LSB  = wide_type'(1) << (FRAC_BITS - 1);

   // config register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_CRACK     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_REACTION  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_DIFFUSION = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELTA_OFFSET   = 2'd3;

   // queue command opcodes
   localparam logic CMD_PASS   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      value_type phi_value;
      logic      is_first;
      logic      is_last;
   } req_type;

   typedef struct packed {
      value_type next_value;
      logic      end_of_step;
   } rsp_type;

   typedef struct packed {
      coef_type  coef_crack;
      value_type coef_reaction;
      value_type coef_diffusion;
      coef_type  delta_offset;
   } cfg_type;

   // PASS: emit mid with end flag = last.
   // UPDATE: emit stencil(left, mid, right); if last, then emit right as end.
   typedef struct packed {
      logic      op;
      value_type left;
      value_type mid;
      value_type right;
      logic      last;
   } cmd_type;

   function automatic value_type sat_add(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = (VALUE_WIDTH+1)'(a) + (VALUE_WIDTH+1)'(b);
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? MIN_VALUE : MAX_VALUE;
      end
      return value_type'(s);
   endfunction

   function automatic value_type sat_sub(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = (VALUE_WIDTH+1)'(a) - (VALUE_WIDTH+1)'(b);
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? MIN_VALUE : MAX_VALUE;
      end
      return value_type'(s);
   endfunction

   // small constant multiple, saturated
   function automatic value_type sat_scale(input value_type a, input logic [3:0] k);
      logic signed [VALUE_WIDTH+3:0] ax;
      logic signed [VALUE_WIDTH+3:0] kx;
      logic signed [VALUE_WIDTH+3:0] p;
      ax = (VALUE_WIDTH+4)'(a);
      kx = $signed((VALUE_WIDTH+4)'(k));
      p  = ax * kx;
      if (p > (VALUE_WIDTH+4)'(MAX_VALUE)) begin
         return MAX_VALUE;
      end
      if (p < (VALUE_WIDTH+4)'(MIN_VALUE)) begin
         return MIN_VALUE;
      end
      return value_type'(p);
   endfunction

   function automatic mag_type mag_of(input value_type a);
      return a[VALUE_WIDTH-1] ? mag_type'(-a) : mag_type'(a);
   endfunction

   // sign and magnitude back to a saturated word
   function automatic value_type sat_mag(input logic neg, input wide_type m);
      if (neg) begin
         if (m >= wide_type'(NEG_MAG)) begin
            return MIN_VALUE;
         end
         return -value_type'(m[VALUE_WIDTH-1:0]);
      end
      if (m > wide_type'(MAX_VALUE)) begin
         return MAX_VALUE;
      end
      return value_type'(m[VALUE_WIDTH-1:0]);
   endfunction

   // round to nearest, ties away from zero, then saturate
   function automatic value_type fx_round(input prod_type p, input logic neg);
      wide_type r;
      r = (wide_type'(p) + HALF_LSB) >> FRAC_BITS;
      return sat_mag(neg, r);
   endfunction

endpackage
`default_nettype wire

/* sv/phase_field_stencil_step.sv */
// Throughput: one word per cycle into the queue while the queue is not
//   full; the back end takes one command at a time, set by the shared
//   multiplier and the bit-serial divider used by the crack term.
// Reset (sync, active high): empties queue and pipeline, closes any open
//   step; coefficients go to 0 and delta_offset to 1.
`default_nettype none
module phase_field_stencil_step (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // grid words in
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  pfs_pkg::req_type                          req_data,
   // updated words out
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output pfs_pkg::rsp_type                          rsp_data,
   // config writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pfs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [pfs_pkg::VALUE_WIDTH-1:0]      csr_wdata
);
   pfs_pkg::cfg_type  cfg_ff, cfg_in;
   logic              q_push, q_full, q_pop, q_empty;
   pfs_pkg::cmd_type  q_push_data, q_pop_data;

   // config regs are always writable; the host must only write while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pfs_pkg::CSR_COEF_CRACK:
               cfg_in.coef_crack = csr_wdata[pfs_pkg::VALUE_WIDTH-2:0];
            pfs_pkg::CSR_COEF_REACTION:
               cfg_in.coef_reaction = pfs_pkg::value_type'(csr_wdata);
            pfs_pkg::CSR_COEF_DIFFUSION:
               cfg_in.coef_diffusion = pfs_pkg::value_type'(csr_wdata);
            pfs_pkg::CSR_DELTA_OFFSET:
               cfg_in.delta_offset = csr_wdata[pfs_pkg::VALUE_WIDTH-2:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_crack     <= '0;
         cfg_ff.coef_reaction  <= '0;
         cfg_ff.coef_diffusion <= '0;
         cfg_ff.delta_offset   <= pfs_pkg::coef_type'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify words, keep the three-point window
   pfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (q_full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   // decoupling queue
   pfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // back: arithmetic sequencer and output register
   pfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (q_empty),
      .queue_data  (q_pop_data),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );
endmodule
`default_nettype wire

/* sv/pfs_queue.sv */
// Short command queue between front and back of the stencil step.
// Depends on pfs_pkg.
`default_nettype none
module pfs_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  pfs_pkg::cmd_type     push_data,
   output logic                 full,
   input  wire logic            pop,
   output pfs_pkg::cmd_type     pop_data,
   output logic                 empty
);
   localparam int PTR_W = (pfs_pkg::QUEUE_DEPTH > 1) ? $clog2(pfs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(pfs_pkg::QUEUE_DEPTH + 1);

   pfs_pkg::cmd_type  slot_ff [pfs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(pfs_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pfs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pfs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

/* sv/pfs_front.sv */
// Front end: takes grid words, tracks the open step and the held points,
// and turns the words into pass or update commands. Depends on pfs_pkg.
`default_nettype none
module pfs_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  pfs_pkg::req_type     req_data,
   input  wire logic            queue_full,
   output logic                 push,
   output pfs_pkg::cmd_type     push_data
);
   logic [1:0]          seen_ff, seen_in;
   pfs_pkg::value_type  older_ff, older_in;
   pfs_pkg::value_type  newer_ff, newer_in;
   logic                take;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      seen_in         = seen_ff;
      older_in        = older_ff;
      newer_in        = newer_ff;
      push            = 1'b0;
      push_data.op    = pfs_pkg::CMD_PASS;
      push_data.left  = older_ff;
      push_data.mid   = req_data.phi_value;
      push_data.right = req_data.phi_value;
      push_data.last  = req_data.is_last;
      if (take) begin
         priority if (req_data.is_first || seen_ff == 2'd0) begin
            push     = 1'b1;
            newer_in = req_data.phi_value;
            seen_in  = req_data.is_last ? 2'd0 : 2'd1;
         end else if (seen_ff == 2'd1) begin
            if (req_data.is_last) begin
               push    = 1'b1;
               seen_in = 2'd0;
            end else begin
               older_in = newer_ff;
               newer_in = req_data.phi_value;
               seen_in  = 2'd2;
            end
         end else begin
            push          = 1'b1;
            push_data.op  = pfs_pkg::CMD_UPDATE;
            push_data.mid = newer_ff;
            older_in      = newer_ff;
            newer_in      = req_data.phi_value;
            if (req_data.is_last) begin
               seen_in = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 2'd0;
         older_ff <= '0;
         newer_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
      end
   end
endmodule
`default_nettype wire

/* sv/pfs_back.sv */
// Back end: sequencer around one shared magnitude multiplier and a
// bit-serial divider; evaluates the stencil update, passes PASS words
// through and drives the output register. Depends on pfs_pkg.
`default_nettype none
module pfs_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  pfs_pkg::cfg_type     cfg,
   input  wire logic            queue_empty,
   input  pfs_pkg::cmd_type     queue_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output pfs_pkg::rsp_type     rsp_data
);
   localparam int W     = pfs_pkg::VALUE_WIDTH;
   localparam int CNT_W = $clog2(2 * W);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SUM  = 5'd1;
   localparam logic [4:0] ST_LAP  = 5'd2;
   localparam logic [4:0] ST_MUL  = 5'd3;
   localparam logic [4:0] ST_RND  = 5'd4;
   localparam logic [4:0] ST_FP   = 5'd5;
   localparam logic [4:0] ST_F    = 5'd6;
   localparam logic [4:0] ST_S    = 5'd7;
   localparam logic [4:0] ST_DIV  = 5'd8;
   localparam logic [4:0] ST_CRK  = 5'd9;
   localparam logic [4:0] ST_ADD1 = 5'd10;
   localparam logic [4:0] ST_ADD2 = 5'd11;
   localparam logic [4:0] ST_ADD3 = 5'd12;
   localparam logic [4:0] ST_EMIT = 5'd13;
   localparam logic [4:0] ST_TAIL = 5'd14;

   localparam logic [2:0] MI_DIFF  = 3'd0;
   localparam logic [2:0] MI_P2    = 3'd1;
   localparam logic [2:0] MI_T     = 3'd2;
   localparam logic [2:0] MI_REACT = 3'd3;
   localparam logic [2:0] MI_P3    = 3'd4;
   localparam logic [2:0] MI_P4    = 3'd5;
   localparam logic [2:0] MI_DEN   = 3'd6;
   localparam logic [2:0] MI_NUM   = 3'd7;

   typedef struct packed {
      pfs_pkg::value_type s1;
      pfs_pkg::value_type s2;
      pfs_pkg::value_type omp;
      pfs_pkg::value_type lap;
      pfs_pkg::value_type diff;
      pfs_pkg::value_type p2;
      pfs_pkg::value_type t;
      pfs_pkg::value_type fp;
      pfs_pkg::value_type react;
      pfs_pkg::value_type p3;
      pfs_pkg::value_type p4;
      pfs_pkg::value_type f;
      pfs_pkg::value_type s;
      pfs_pkg::value_type crack;
      pfs_pkg::value_type acc;
      pfs_pkg::mag_type   den;
   } dp_type;

   logic [4:0]          state_ff, state_in;
   logic [2:0]          midx_ff, midx_in;
   pfs_pkg::cmd_type    cmd_ff, cmd_in;
   dp_type              dp_ff, dp_in;
   pfs_pkg::prod_type   prod_ff, prod_in;
   logic                pneg_ff, pneg_in;
   logic [W:0]          rem_ff, rem_in;
   pfs_pkg::prod_type   dq_ff, dq_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   pfs_pkg::rsp_type    out_ff, out_in;

   pfs_pkg::value_type  mul_x, mul_y;
   pfs_pkg::value_type  rnd;
   logic [W:0]          rem_sh;
   logic                rem_ge;
   logic                out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rnd       = pfs_pkg::fx_round(prod_ff, pneg_ff);
   assign rem_sh    = {rem_ff[W-1:0], dq_ff[2*W-1]};
   assign rem_ge    = rem_sh >= {1'b0, dp_ff.den};

   // operand select for the shared multiplier
   always_comb begin
      unique case (midx_ff)
         MI_DIFF:  begin mul_x = cfg.coef_diffusion; mul_y = dp_ff.lap; end
         MI_P2:    begin mul_x = cmd_ff.mid;         mul_y = cmd_ff.mid; end
         MI_T:     begin mul_x = dp_ff.p2;           mul_y = dp_ff.omp; end
         MI_REACT: begin mul_x = cfg.coef_reaction;  mul_y = dp_ff.fp; end
         MI_P3:    begin mul_x = dp_ff.p2;           mul_y = cmd_ff.mid; end
         MI_P4:    begin mul_x = dp_ff.p3;           mul_y = cmd_ff.mid; end
         MI_DEN:   begin mul_x = dp_ff.s;            mul_y = dp_ff.s; end
         MI_NUM:   begin mul_x = pfs_pkg::value_type'({1'b0, cfg.coef_crack});
                         mul_y = dp_ff.fp; end
         default:  begin mul_x = '0; mul_y = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      midx_in      = midx_ff;
      cmd_in       = cmd_ff;
      dp_in        = dp_ff;
      prod_in      = prod_ff;
      pneg_in      = pneg_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               cmd_in = queue_data;
               if (queue_data.op == pfs_pkg::CMD_PASS) begin
                  dp_in.acc = queue_data.mid;
                  state_in  = ST_EMIT;
               end else begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            dp_in.s1  = pfs_pkg::sat_add(cmd_ff.left, cmd_ff.right);
            dp_in.s2  = pfs_pkg::sat_add(cmd_ff.mid, cmd_ff.mid);
            dp_in.omp = pfs_pkg::sat_sub(pfs_pkg::ONE_VALUE, cmd_ff.mid);
            state_in  = ST_LAP;
         end
         ST_LAP: begin
            dp_in.lap = pfs_pkg::sat_sub(dp_ff.s1, dp_ff.s2);
            midx_in   = MI_DIFF;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = pfs_pkg::prod_type'(pfs_pkg::mag_of(mul_x)) *
                       pfs_pkg::prod_type'(pfs_pkg::mag_of(mul_y));
            pneg_in  = mul_x[W-1] ^ mul_y[W-1];
            state_in = ST_RND;
         end
         ST_RND: begin
            unique case (midx_ff)
               MI_DIFF: begin
                  dp_in.diff = rnd;
                  midx_in    = MI_P2;
                  state_in   = ST_MUL;
               end
               MI_P2: begin
                  dp_in.p2 = rnd;
                  midx_in  = MI_T;
                  state_in = ST_MUL;
               end
               MI_T: begin
                  dp_in.t  = rnd;
                  state_in = ST_FP;
               end
               MI_REACT: begin
                  dp_in.react = rnd;
                  // crack term only for p >= 0 with nonzero source and gain
                  if (!cmd_ff.mid[W-1] && dp_ff.fp != '0 && cfg.coef_crack != '0) begin
                     midx_in  = MI_P3;
                     state_in = ST_MUL;
                  end else begin
                     dp_in.crack = '0;
                     state_in    = ST_ADD1;
                  end
               end
               MI_P3: begin
                  dp_in.p3 = rnd;
                  midx_in  = MI_P4;
                  state_in = ST_MUL;
               end
               MI_P4: begin
                  dp_in.p4 = rnd;
                  state_in = ST_F;
               end
               MI_DEN: begin
                  dp_in.den = pfs_pkg::mag_of(rnd);
                  if (pfs_pkg::mag_of(rnd) == '0) begin
                     // zero denominator: limit opposite in sign to the source
                     dp_in.crack = (dp_ff.fp > 0) ? pfs_pkg::MIN_VALUE : pfs_pkg::MAX_VALUE;
                     state_in    = ST_ADD1;
                  end else begin
                     midx_in  = MI_NUM;
                     state_in = ST_MUL;
                  end
               end
               MI_NUM: begin
                  dq_in    = prod_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_FP: begin
            dp_in.fp = pfs_pkg::sat_scale(dp_ff.t, 4'd12);
            midx_in  = MI_REACT;
            state_in = ST_MUL;
         end
         ST_F: begin
            dp_in.f  = pfs_pkg::sat_sub(pfs_pkg::sat_scale(dp_ff.p3, 4'd4),
                                        pfs_pkg::sat_scale(dp_ff.p4, 4'd3));
            state_in = ST_S;
         end
         ST_S: begin
            dp_in.s  = pfs_pkg::sat_add(dp_ff.f,
                          pfs_pkg::value_type'({1'b0, cfg.delta_offset}));
            midx_in  = MI_DEN;
            state_in = ST_MUL;
         end
         ST_DIV: begin
            rem_in = rem_ge ? rem_sh - {1'b0, dp_ff.den} : rem_sh;
            dq_in  = {dq_ff[2*W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(2 * W - 1)) begin
               state_in = ST_CRK;
            end
         end
         ST_CRK: begin
            dp_in.crack = pfs_pkg::sat_mag(dp_ff.fp > 0, {1'b0, dq_ff});
            state_in    = ST_ADD1;
         end
         ST_ADD1: begin
            dp_in.acc = pfs_pkg::sat_add(cmd_ff.mid, dp_ff.diff);
            state_in  = ST_ADD2;
         end
         ST_ADD2: begin
            dp_in.acc = pfs_pkg::sat_add(dp_ff.acc, dp_ff.react);
            state_in  = ST_ADD3;
         end
         ST_ADD3: begin
            dp_in.acc = pfs_pkg::sat_add(dp_ff.acc, dp_ff.crack);
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.next_value  = dp_ff.acc;
               out_in.end_of_step = (cmd_ff.op == pfs_pkg::CMD_PASS) && cmd_ff.last;
               state_in = (cmd_ff.op == pfs_pkg::CMD_UPDATE && cmd_ff.last) ?
                          ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               out_valid_in       = 1'b1;
               out_in.next_value  = cmd_ff.right;
               out_in.end_of_step = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         midx_ff      <= MI_DIFF;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         midx_ff      <= midx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dp_ff   <= dp_in;
      prod_ff <= prod_in;
      pneg_ff <= pneg_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

`ifndef SYNTH
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dp_ff.den != '0)
      else $error("divider running on zero denominator");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff != ST_IDLE)
      else $error("command popped but sequencer stayed idle");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> out_valid_ff && $stable(out_ff))
      else $error("waiting result overwritten");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE && !queue_empty)
      else $error("pop outside idle or from empty queue");
`endif
endmodule
`default_nettype wire
